@@ src/bwarp_pkg.sv @@
package bwarp_pkg;

  // image geometry and number format
  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int FRAC_BITS = 8;

  // fixed field widths
  localparam int PIX_W  = 16;
  localparam int DISP_W = 16;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 9;

  // derived widths
  localparam int TAP_W  = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int SIZE_W = TAP_W + 1;
  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int POS_W  = (((IDX_W + FRAC_BITS) > DISP_W) ? (IDX_W + FRAC_BITS) : DISP_W) + 2;
  localparam int H_W    = PIX_W + FRAC_BITS + 2;
  localparam int V_W    = H_W + FRAC_BITS + 2;

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] COLS_RST = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'(MAX_ROWS);

  // item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WARP = 1'b1;

  // taps of one axis: first index, second index, weight of the second
  typedef struct packed {
    logic [TAP_W-1:0] a;
    logic [TAP_W-1:0] b;
    logic [WGT_W-1:0] w;
  } bw_tap_t;

  // side info that travels with the pixel reads
  typedef struct packed {
    logic             vld;
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
  } bw_wgt_t;

endpackage

@@ src/bwarp_axis.sv @@
module bwarp_axis import bwarp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic signed [DISP_W-1:0] disp_i,
  input  logic [TAP_W-1:0]         n_m1_i,
  output bw_tap_t                  tap_o
);

  localparam int IP_W = POS_W - 1 - FRAC_BITS;

  logic signed [POS_W-1:0] pos;
  logic [IP_W-1:0]         ip;
  logic                    neg_small;
  bw_tap_t                 tap_d, tap_q;

  always_comb begin
    pos       = $signed(POS_W'({idx_i, {FRAC_BITS{1'b0}}})) + POS_W'(disp_i);
    ip        = pos[POS_W-2:FRAC_BITS];
    // position in (-1,0): truncates to 0, extrapolates from pixels 0 and 1
    neg_small = (&pos[POS_W-1:FRAC_BITS]) && (|pos[FRAC_BITS-1:0]);
    tap_d     = '0;
    if (pos[POS_W-1]) begin
      if (neg_small && (n_m1_i != '0)) begin
        tap_d.b = TAP_W'(1);
        tap_d.w = pos[WGT_W-1:0];
      end
    end else if (ip >= IP_W'(n_m1_i)) begin
      tap_d.a = n_m1_i;
      tap_d.b = n_m1_i;
    end else begin
      tap_d.a = TAP_W'(ip);
      tap_d.b = TAP_W'(ip) + TAP_W'(1);
      tap_d.w = {1'b0, pos[FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

@@ src/bwarp_store.sv @@
module bwarp_store import bwarp_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr0_i,
  input  logic [ADDR_W-1:0] raddr1_i,
  output logic [PIX_W-1:0]  rdata0_o,
  output logic [PIX_W-1:0]  rdata1_o
);

  logic [PIX_W-1:0] mem_q [1 << ADDR_W];
  logic [PIX_W-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data held while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ src/bwarp_interp.sv @@
module bwarp_interp import bwarp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  bw_wgt_t          wgt_i,
  input  logic [PIX_W-1:0] p11_i,
  input  logic [PIX_W-1:0] p21_i,
  input  logic [PIX_W-1:0] p12_i,
  input  logic [PIX_W-1:0] p22_i,
  output logic             vld_o,
  output logic [PIX_W-1:0] value_o
);

  localparam int D_W  = PIX_W + 1;
  localparam int DH_W = H_W + 1;
  localparam int QM_W = V_W - 2 * FRAC_BITS;
  localparam logic [V_W-1:0]  HALF    = V_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [QM_W-1:0] POS_LIM = QM_W'((1 << (PIX_W - 1)) - 1);
  localparam logic [QM_W-1:0] NEG_LIM = QM_W'(1 << (PIX_W - 1));

  logic signed [D_W-1:0]   dx1, dx2;
  logic signed [WGT_W-1:0] wx;
  logic signed [H_W-1:0]   h1_d, h2_d, h1_q, h2_q;
  logic [WGT_W-1:0]        wy_q;
  logic signed [DH_W-1:0]  dh;
  logic signed [V_W-1:0]   v_d, v_q;
  logic [V_W-1:0]          mag, rsum;
  logic [QM_W-1:0]         qm;
  logic [PIX_W-1:0]        val_d, val_q;
  logic                    v4_q, v5_q, v6_q;

  // horizontal pass on both rows
  always_comb begin
    wx   = $signed(wgt_i.wx);
    dx1  = D_W'($signed(p21_i)) - D_W'($signed(p11_i));
    dx2  = D_W'($signed(p22_i)) - D_W'($signed(p12_i));
    h1_d = (H_W'($signed(p11_i)) <<< FRAC_BITS) + H_W'(dx1) * H_W'(wx);
    h2_d = (H_W'($signed(p12_i)) <<< FRAC_BITS) + H_W'(dx2) * H_W'(wx);
  end

  // vertical pass, exact in 2*FRAC_BITS fraction bits
  always_comb begin
    dh  = DH_W'(h2_q) - DH_W'(h1_q);
    v_d = (V_W'(h1_q) <<< FRAC_BITS) + V_W'(dh) * V_W'($signed(wy_q));
  end

  // round half away from zero, then saturate
  always_comb begin
    mag  = v_q[V_W-1] ? V_W'(-v_q) : V_W'(v_q);
    rsum = mag + HALF;
    qm   = rsum[V_W-1:2*FRAC_BITS];
    if (!v_q[V_W-1]) begin
      val_d = (qm > POS_LIM) ? POS_LIM[PIX_W-1:0] : qm[PIX_W-1:0];
    end else begin
      val_d = (qm > NEG_LIM) ? NEG_LIM[PIX_W-1:0] : (~qm[PIX_W-1:0] + PIX_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q  <= h1_d;
      h2_q  <= h2_d;
      wy_q  <= wgt_i.wy;
      v_q   <= v_d;
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= wgt_i.vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign vld_o   = v6_q;
  assign value_o = val_q;

endmodule

@@ src/bilinear_image_warp_core.sv @@
// A warp item reaches m_axis via the tap, address, store read, interp and output registers.
// Throughput: one item per cycle while the skid entry is empty, loads and warps mixed freely;
// a load gives no result. The rate is set by the two-copy pixel store: each copy has two read
// ports, so all four taps of a warp item are read at once while a load writes both copies.
// Reset: clears valid bits and sets both image size registers to 256; the pixel store is not
// cleared, and a pixel must be loaded before it is sampled.
module bilinear_image_warp_core import bwarp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // col[7:0], row[15:8], pixel_in[31:16],
                                              // disp_x[47:32], disp_y[63:48]
  input  logic [0:0]           s_axis_tuser,  // op[0]: 0 load, 1 warp
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // warped_value[15:0]
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Size registers and their effective (clamped) last index
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  cols_q, rows_q;
  logic [TAP_W-1:0]  wm1, hm1;
  logic [SIZE_W-1:0] wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_ROWS: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the maximum acts as the maximum
  always_comb begin
    if (cols_q == '0) begin
      wm1 = '0;
    end else if (cols_q > CFG_W'(MAX_COLS)) begin
      wm1 = TAP_W'(MAX_COLS - 1);
    end else begin
      wm1 = TAP_W'(cols_q - CFG_W'(1));
    end
    if (rows_q == '0) begin
      hm1 = '0;
    end else if (rows_q > CFG_W'(MAX_ROWS)) begin
      hm1 = TAP_W'(MAX_ROWS - 1);
    end else begin
      hm1 = TAP_W'(rows_q - CFG_W'(1));
    end
    wd = SIZE_W'(wm1) + SIZE_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Global advance. Only a full skid stage stops the pipeline, and that flag
  // is a register, so tready never depends on m_axis_tready combinationally.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // unpack the input item
  logic [IDX_W-1:0]         in_col, in_row;
  logic [PIX_W-1:0]         in_pix;
  logic signed [DISP_W-1:0] in_dx, in_dy;

  assign in_col = s_axis_tdata[IDX_W-1:0];
  assign in_row = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_pix = s_axis_tdata[2*IDX_W+PIX_W-1:2*IDX_W];
  assign in_dx  = $signed(s_axis_tdata[2*IDX_W+PIX_W+DISP_W-1:2*IDX_W+PIX_W]);
  assign in_dy  = $signed(s_axis_tdata[2*IDX_W+PIX_W+2*DISP_W-1:2*IDX_W+PIX_W+DISP_W]);

  // ---------------------------------------------------------------------------
  // Stage 1: per-axis tap indices and weights
  // ---------------------------------------------------------------------------
  bw_tap_t          xt, yt;
  logic             v1_q, op1_q;
  logic [IDX_W-1:0] col1_q, row1_q;
  logic [PIX_W-1:0] pix1_q;

  bwarp_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .idx_i  (in_col),
    .disp_i (in_dx),
    .n_m1_i (wm1),
    .tap_o  (xt)
  );

  bwarp_axis u_axis_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .idx_i  (in_row),
    .disp_i (in_dy),
    .n_m1_i (hm1),
    .tap_o  (yt)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= s_axis_tuser[0];
      col1_q <= in_col;
      row1_q <= in_row;
      pix1_q <= in_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: store addresses. A load borrows the first-tap address slot.
  // ---------------------------------------------------------------------------
  logic [TAP_W-1:0]        ya, xa;
  logic [TAP_W+SIZE_W-1:0] base1, base2;
  logic [ADDR_W-1:0]       a11_d, a21_d, a12_d, a22_d;
  logic [ADDR_W-1:0]       a11_q, a21_q, a12_q, a22_q;
  logic                    ld_ok_d, ld_ok2_q;
  logic                    v2_q, op2_q;
  logic [PIX_W-1:0]        pix2_q;
  logic [WGT_W-1:0]        wx2_q, wy2_q;

  always_comb begin
    ya      = (op1_q == OP_WARP) ? yt.a : TAP_W'(row1_q);
    xa      = (op1_q == OP_WARP) ? xt.a : TAP_W'(col1_q);
    base1   = ya * wd;
    base2   = yt.b * wd;
    a11_d   = ADDR_W'(base1) + ADDR_W'(xa);
    a21_d   = ADDR_W'(base1) + ADDR_W'(xt.b);
    a12_d   = ADDR_W'(base2) + ADDR_W'(xt.a);
    a22_d   = ADDR_W'(base2) + ADDR_W'(xt.b);
    // loads outside the current image are dropped
    ld_ok_d = (SIZE_W'(col1_q) <= SIZE_W'(wm1)) && (SIZE_W'(row1_q) <= SIZE_W'(hm1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q    <= op1_q;
      pix2_q   <= pix1_q;
      ld_ok2_q <= ld_ok_d;
      a11_q    <= a11_d;
      a21_q    <= a21_d;
      a12_q    <= a12_d;
      a22_q    <= a22_d;
      wx2_q    <= xt.w;
      wy2_q    <= yt.w;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pixel store, two copies with two read ports each.
  // Items stay in order, so a load always lands before any later warp reads.
  // ---------------------------------------------------------------------------
  logic             store_we;
  logic [PIX_W-1:0] p11, p21, p12, p22;
  logic             v3_q;
  logic [WGT_W-1:0] wx3_q, wy3_q;
  bw_wgt_t          wgt3;

  assign store_we = en && v2_q && (op2_q == OP_LOAD) && ld_ok2_q;

  bwarp_store u_store_top (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (store_we),
    .waddr_i  (a11_q),
    .wdata_i  (pix2_q),
    .raddr0_i (a11_q),
    .raddr1_i (a21_q),
    .rdata0_o (p11),
    .rdata1_o (p21)
  );

  bwarp_store u_store_bot (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (store_we),
    .waddr_i  (a11_q),
    .wdata_i  (pix2_q),
    .raddr0_i (a12_q),
    .raddr1_i (a22_q),
    .rdata0_o (p12),
    .rdata1_o (p22)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx3_q <= wx2_q;
      wy3_q <= wy2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q && (op2_q == OP_WARP);
    end
  end

  assign wgt3 = '{vld: v3_q, wx: wx3_q, wy: wy3_q};

  // ---------------------------------------------------------------------------
  // Stages 4-6: horizontal, vertical, round and saturate
  // ---------------------------------------------------------------------------
  logic             res_vld;
  logic [PIX_W-1:0] res_val;

  bwarp_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .wgt_i   (wgt3),
    .p11_i   (p11),
    .p21_i   (p21),
    .p12_i   (p12),
    .p22_i   (p22),
    .vld_o   (res_vld),
    .value_o (res_val)
  );

  // ---------------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------------
  logic             out_vld_q;
  logic [PIX_W-1:0] out_q, skid_q;
  logic             push, take;

  assign push = en && res_vld;
  assign take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_q <= res_val;
      end else begin
        out_q <= res_val;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && m_axis_tready) |=> (!skid_vld_q && out_vld_q))
    else $error("skid entry not moved to output register");

  a_stalled_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_vld_q && !m_axis_tready) |=> (skid_vld_q && out_vld_q))
    else $error("result pushed into stalled output was dropped");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bwarp_pkg::*;

  localparam int ONE       = 1 << FRAC_BITS;   // one pixel in position units
  localparam int HALF_LSB  = (ONE * ONE) / 2;  // rounding offset after both axes
  localparam int N_PHASES  = 11;
  localparam int MIX_ITEMS = 60;               // random items per phase after the image load
  localparam int HOLD_LEN  = 300;              // long sink hold-off, in cycles

  // fixed part of the phase plan: (cols, rows); later phases pick small random sizes
  localparam int COLS_PLAN [7] = '{1, 256, 0, 16, 20, 511, 5};
  localparam int ROWS_PLAN [7] = '{1, 1, 511, 16, 10, 0, 7};

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic        op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] pixel;
    logic [15:0] disp_x;
    logic [15:0] disp_y;
  } warp_item_t;

  // Image mirror plus bilinear predictor; expected warped values wait in order.
  class warp_scoreboard;
    logic [15:0]      img    [MAX_COLS*MAX_ROWS];
    bit               loaded [MAX_COLS*MAX_ROWS];
    logic [CFG_W-1:0] cols_cfg;
    logic [CFG_W-1:0] rows_cfg;
    logic [15:0]      warp_q [$];
    int               errors;

    function new();
      cols_cfg = COLS_RST;
      rows_cfg = ROWS_RST;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_COLS) cols_cfg = data;
      else rows_cfg = data;
    endfunction

    // zero acts as 1, anything past the store size as the maximum
    function int eff_size(logic [CFG_W-1:0] r, int maxv);
      if (r == 0) return 1;
      if (int'(r) > maxv) return maxv;
      return int'(r);
    endfunction

    function int width();
      return eff_size(cols_cfg, MAX_COLS);
    endfunction

    function int height();
      return eff_size(rows_cfg, MAX_ROWS);
    endfunction

    // one axis: truncate toward zero, clamp both taps, weight measured from tap a
    function void axis_taps(input int pos, input int n, output int a, output int b,
                            output int w);
      int i;
      i = pos / ONE;
      a = (i < 0) ? 0 : (i > n - 1) ? n - 1 : i;
      b = (i + 1 < 0) ? 0 : (i + 1 > n - 1) ? n - 1 : i + 1;
      w = (a != b) ? pos - a * ONE : 0;
    endfunction

    function bit taps_loaded(logic [7:0] col, logic [7:0] row, logic [15:0] dx,
                             logic [15:0] dy);
      int wd, xa, xb, xw, ya, yb, yw;
      wd = width();
      axis_taps(int'(col) * ONE + int'($signed(dx)), wd, xa, xb, xw);
      axis_taps(int'(row) * ONE + int'($signed(dy)), height(), ya, yb, yw);
      return loaded[ya*wd + xa] && loaded[ya*wd + xb] &&
             loaded[yb*wd + xa] && loaded[yb*wd + xb];
    endfunction

    function longint tap(int x, int y, int wd);
      return longint'($signed(img[y*wd + x]));
    endfunction

    function void note_input(warp_item_t it);
      int     wd, ht, xa, xb, xw, ya, yb, yw;
      longint h1, h2, v, q;
      wd = width();
      ht = height();
      if (it.op == OP_LOAD) begin
        // loads outside the current image are dropped
        if (int'(it.col) < wd && int'(it.row) < ht) begin
          img[int'(it.row)*wd + int'(it.col)]    = it.pixel;
          loaded[int'(it.row)*wd + int'(it.col)] = 1'b1;
        end
        return;
      end
      axis_taps(int'(it.col) * ONE + int'($signed(it.disp_x)), wd, xa, xb, xw);
      axis_taps(int'(it.row) * ONE + int'($signed(it.disp_y)), ht, ya, yb, yw);
      h1 = tap(xa, ya, wd) * ONE + (tap(xb, ya, wd) - tap(xa, ya, wd)) * xw;
      h2 = tap(xa, yb, wd) * ONE + (tap(xb, yb, wd) - tap(xa, yb, wd)) * xw;
      v  = h1 * ONE + (h2 - h1) * yw;
      // nearest, ties away from zero, then saturate
      if (v >= 0) q = (v + HALF_LSB) / (ONE * ONE);
      else q = -((-v + HALF_LSB) / (ONE * ONE));
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      warp_q.insert(warp_q.size(), q[15:0]);
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (warp_q.size() == 0) begin
        $display("%0t: warped value %0d with none expected", $time, $signed(got));
        errors++;
        return;
      end
      want = warp_q.pop_front();
      if (got !== want) begin
        $display("%0t: warped value mismatch: expected %0d, got %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function int pending();
      return warp_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;   // col[7:0], row[15:8], pixel_in[31:16],
                                        // disp_x[47:32], disp_y[63:48]
  logic [0:0]           s_axis_tuser;   // op[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;   // warped_value[15:0]
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int src_idle_pct   = 0;  // chance per cycle that the source holds off
  int sink_stall_pct = 0;  // chance per cycle that the sink drops tready
  int sink_hold      = 0;  // pending long hold-off, counted down by the sink process

  warp_scoreboard sb;

  bilinear_image_warp_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Result side: every handshake is checked against the oldest expected value.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Sink: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offers one item; valid stays high on return so back-to-back items need no gap.
  task automatic send_item(logic op, logic [7:0] col, logic [7:0] row, logic [15:0] pixel,
                           logic [15:0] dx, logic [15:0] dy);
    warp_item_t it;
    it = '{op, col, row, pixel, dx, dy};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {dy, dx, pixel, row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Both size registers, back to back; only called with the core idle.
  task automatic write_size(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COLS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(CFG_COLS, cols);
    sb.write_reg(CFG_ROWS, rows);
  endtask

  // Source goes quiet until every warp result is back, then lets in-flight loads land.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Pixel values lean on the saturating extremes.
  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly sub-pixel and few-pixel shifts, some whole-pixel steps and range ends.
  function automatic logic [15:0] rand_disp();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(1023) - 512);
      4: return 16'h8000;
      5: return 16'h7FFF;
      6: return 16'hFF80;   // half a pixel back: extrapolation near the left/top edge
      7: return 16'(($urandom_range(8) - 4) * ONE);
      default: return 16'($urandom);
    endcase
  endfunction

  // Every pixel of the current image, in raster order.
  task automatic load_image(int wd, int ht);
    for (int r = 0; r < ht; r++) begin
      for (int c = 0; c < wd; c++) send_item(OP_LOAD, 8'(c), 8'(r), rand_pixel(),
                                               16'($urandom), 16'($urandom));
    end
  endtask

  // Warp-heavy random traffic with overwrites and out-of-image loads mixed in.
  task automatic run_mix(int n_items);
    int         wd, ht;
    logic [7:0] col, row;
    logic [15:0] dx, dy;
    wd = sb.width();
    ht = sb.height();
    for (int k = 0; k < n_items; k++) begin
      col = $urandom_range(1) ? 8'($urandom_range(wd - 1)) : 8'($urandom_range(255));
      row = $urandom_range(1) ? 8'($urandom_range(ht - 1)) : 8'($urandom_range(255));
      if ($urandom_range(99) < 15) begin
        send_item(OP_LOAD, col, row, rand_pixel(), 16'($urandom), 16'($urandom));
      end else begin
        dx = rand_disp();
        dy = rand_disp();
        // never sample a pixel that has not been written since reset
        if (sb.taps_loaded(col, row, dx, dy)) send_item(OP_WARP, col, row, rand_pixel(), dx, dy);
      end
    end
  endtask

  initial begin
    int cols, rows;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COLS;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 image, row 0 = {0, 1}, row 1 = {0, -1}
    write_size(9'd2, 9'd2);
    send_item(OP_LOAD, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'd1, 8'd0, 16'h0001, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 8'd0, 8'd1, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'd1, 8'd1, 16'hFFFF, 16'h0000, 16'h0000);
    // loads just outside the image are dropped
    send_item(OP_LOAD, 8'd2, 8'd0, 16'h1234, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'd0, 8'd2, 16'h4321, 16'h0000, 16'h0000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h0080, 16'h0000);  // +0.5 tie rounds up
    send_item(OP_WARP, 8'd0, 8'd1, 16'h0000, 16'h0080, 16'h0000);  // -0.5 tie rounds down
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h0080, 16'h0080);
    send_item(OP_WARP, 8'd255, 8'd255, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h8000, 16'h8000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'hFE80, 16'h0000);  // -1.5 truncates to -1
    // row 0 = {max, min}: extrapolation and interpolation that saturate
    send_item(OP_LOAD, 8'd0, 8'd0, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'd1, 8'd0, 16'h8000, 16'h0000, 16'h0000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'hFF80, 16'h0000);
    send_item(OP_WARP, 8'd1, 8'd0, 16'h0000, 16'hFF80, 16'h0000);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'h0180, 16'h0000);  // both taps clamp to col 1
    send_item(OP_WARP, 8'd1, 8'd0, 16'h0000, 16'h0000, 16'hFF80);
    send_item(OP_WARP, 8'd0, 8'd0, 16'h0000, 16'hFF80, 16'hFF80);
    drain();

    // Random phases. Each writes both sizes, reloads the image (except the size-change
    // phase, which reads earlier loads at their new positions) and then mixes traffic.
    for (int p = 0; p < N_PHASES; p++) begin
      case (idle_mode_e'(p % 4))
        IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        IDLE_SRC:  begin src_idle_pct = 80; sink_stall_pct = 0;  end
        IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default:   begin src_idle_pct = 9;  sink_stall_pct = 9;  end
      endcase
      if (p < 7) begin
        cols = COLS_PLAN[p];
        rows = ROWS_PLAN[p];
      end else begin
        cols = $urandom_range(2, 12);
        rows = $urandom_range(2, 12);
      end
      write_size(CFG_W'(cols), CFG_W'(rows));
      if (p != 4) load_image(sb.width(), sb.height());
      // back-pressure: sink holds off while the source keeps offering items
      if (p == 4) sink_hold = HOLD_LEN;
      run_mix(MIX_ITEMS);
      drain();
    end

    if (sb.errors == 0) begin
      $display("** bilinear_image_warp_core: PASSED **");
    end else begin
      $display("** bilinear_image_warp_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("** bilinear_image_warp_core: FAILED **");
    $finish;
  end

endmodule
